### rtl/pose_delta_to_body_motion_core_macros.svh
// assertion helpers shared by pdbm_front, pdbm_back and pdbm_queue
`ifndef POSE_DELTA_TO_BODY_MOTION_CORE_MACROS_SVH
`define POSE_DELTA_TO_BODY_MOTION_CORE_MACROS_SVH

// implication checked on every edge outside reset
`define PDBM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked with the consequent in the next cycle
`define PDBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pdbm_pkg.sv
`timescale 1ns / 1ps
package pdbm_pkg;

  localparam int CordicStagesDef = 24;
  localparam int CordicStagesMax = 32;
  localparam int QueueDepth = 4;

  localparam logic signed [27:0] PiQ = 28'sd52707179;
  localparam logic signed [27:0] TwoPiQ = 28'sd105414357;
  localparam logic signed [33:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [33:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;

  localparam logic [15:0] LinDzReset = 16'd66;
  localparam logic [23:0] AngDzReset = 24'd16777;

  localparam logic CfgIdxLinear = 1'b0;
  localparam logic CfgIdxAngular = 1'b1;

  // classified item between front and back
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [33:0] z;
    logic               neg;
    logic signed [27:0] rot;
  } item_t;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] a;
    case (i)
      0: a = 34'sd843314856;
      1: a = 34'sd497837829;
      2: a = 34'sd263043836;
      3: a = 34'sd133525158;
      4: a = 34'sd67021686;
      5: a = 34'sd33543515;
      6: a = 34'sd16775850;
      7: a = 34'sd8388437;
      8: a = 34'sd4194282;
      9: a = 34'sd2097149;
      10: a = 34'sd1048575;
      11: a = 34'sd524287;
      12: a = 34'sd262143;
      13: a = 34'sd131071;
      14: a = 34'sd65535;
      15: a = 34'sd32767;
      16: a = 34'sd16383;
      17: a = 34'sd8191;
      18: a = 34'sd4095;
      19: a = 34'sd2047;
      20: a = 34'sd1023;
      21: a = 34'sd511;
      22: a = 34'sd255;
      23: a = 34'sd127;
      24: a = 34'sd63;
      25: a = 34'sd31;
      26: a = 34'sd15;
      27: a = 34'sd7;
      28: a = 34'sd3;
      29: a = 34'sd1;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage

### rtl/pose_delta_to_body_motion_core.sv
`timescale 1ns / 1ps
// channel  | handshake            | payload
// in       | in_valid / in_ready  | start_x .. end_heading
// out      | out_valid / out_ready| forward, sideward, rotation, saturated
// cfg      | cfg_we               | cfg_idx, cfg_data
// one pose pair per cycle while in_ready is high; out_valid rises once the input transfer
// has passed the front stages, the unrolled cordic pipeline (one stage per iteration), back stages a to c and the queue
// the whole pipeline holds when three results wait in the queue, one more
// sits at the pipeline end and out_ready is low; in_ready then drops
// in_ready follows out_ready combinationally through that condition
// rst_n is synchronous; dead zones return to 66 and 16777
module pose_delta_to_body_motion_core #(
  parameter int CORDIC_STAGES = pdbm_pkg::CordicStagesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_start_heading,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [31:0] in_end_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_forward,
  output logic signed [31:0] out_sideward,
  output logic signed [26:0] out_rotation,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [23:0]        cfg_data
);
  localparam int QD = pdbm_pkg::QueueDepth;
  localparam int CW = $clog2(QD + 1);

  logic [15:0] lin_dz_r;
  logic [23:0] ang_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_dz_r <= pdbm_pkg::LinDzReset;
      ang_dz_r <= pdbm_pkg::AngDzReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        pdbm_pkg::CfgIdxLinear:  lin_dz_r <= cfg_data[15:0];
        pdbm_pkg::CfgIdxAngular: ang_dz_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline stalls whole when queue could overflow
  logic en, fv, bv, wr, rd;
  logic [CW-1:0] cnt;
  pdbm_pkg::item_t item;
  logic signed [31:0] f, s;
  logic signed [26:0] r;
  logic sat;
  logic [91:0] qout;

  assign en = (cnt == '0) || (cnt < CW'(QD - 1)) || (!bv) || rd;
  assign in_ready = en;

  pdbm_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_valid && in_ready),
    .start_x(in_start_x), .start_y(in_start_y), .start_heading(in_start_heading),
    .end_x(in_end_x), .end_y(in_end_y), .end_heading(in_end_heading),
    .out_v(fv), .item(item)
  );

  pdbm_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(fv), .item(item),
    .lin_dz(lin_dz_r), .ang_dz(ang_dz_r), .out_v(bv),
    .forward(f), .sideward(s), .rotation(r), .saturated(sat)
  );

  assign wr = bv && en;
  assign rd = out_valid && out_ready;

  pdbm_queue #(.DEPTH(QD), .W(92)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr(wr), .wdata({f, s, r, sat}), .rd(rd),
    .nempty(out_valid), .rdata(qout), .cnt(cnt)
  );

  assign out_forward   = qout[91:60];
  assign out_sideward  = qout[59:28];
  assign out_rotation  = qout[27:1];
  assign out_saturated = qout[0];
endmodule

### rtl/pdbm_wrap.sv
`timescale 1ns / 1ps
// heading wrap into [-pi, pi): one register between the two steps
// step 1: reduce by 2pi multiples using high bits; step 2: final correction
// 2pi in q8.24 is one lsb short of two pi; a -pi input is caught by a compare and passes as is
// and every other heading lands in (-pi, pi)
module pdbm_wrap (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] theta,
  output logic signed [27:0] wrapped
);
  // theta >> 24 scaled by 1/2pi gives k estimate; remainder theta - k*2pi is small
  logic signed [7:0]  k_est;
  logic signed [42:0] red;
  logic signed [42:0] red_r;
  logic               neg_pi_r;
  logic signed [42:0] a0, a1, a2, a3;
  logic signed [42:0] sel;

  function automatic logic signed [42:0] TwoPiQ_ext();
    return 43'(pdbm_pkg::TwoPiQ);
  endfunction

  // k = floor(theta / 2pi) roughly: theta >> 24 scaled by 1/2pi ~ 163/1024
  assign k_est = 8'(($signed(theta[31:24]) * 16'sd163) >>> 10);
  assign red = 43'(theta) - 43'(k_est) * 43'(TwoPiQ_ext());

  always_ff @(posedge clk) begin
    if (en) begin
      red_r    <= red;
      neg_pi_r <= (theta == -32'(pdbm_pkg::PiQ));
    end
  end

  // residual lies within a few periods; pick the one in (-pi, pi)
  always_comb begin
    a0 = red_r - 43'sd2 * TwoPiQ_ext();
    a1 = red_r - TwoPiQ_ext();
    a2 = red_r;
    a3 = red_r + TwoPiQ_ext();
    sel = red_r + 43'sd2 * TwoPiQ_ext();
    if (a0 > -43'(pdbm_pkg::PiQ)) begin
      sel = a0;
    end else if (a1 > -43'(pdbm_pkg::PiQ)) begin
      sel = a1;
    end else if (a2 > -43'(pdbm_pkg::PiQ)) begin
      sel = a2;
    end else if (a3 > -43'(pdbm_pkg::PiQ)) begin
      sel = a3;
    end
  end

  assign wrapped = neg_pi_r ? -pdbm_pkg::PiQ : 28'(sel);
endmodule

### rtl/pdbm_front.sv
`timescale 1ns / 1ps
// front: differences, heading wraps, quadrant fold, rotation delta
// two register stages, an in-flight valid per stage
module pdbm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_v,
  input  logic signed [31:0]    start_x,
  input  logic signed [31:0]    start_y,
  input  logic signed [31:0]    start_heading,
  input  logic signed [31:0]    end_x,
  input  logic signed [31:0]    end_y,
  input  logic signed [31:0]    end_heading,
  output logic                  out_v,
  output pdbm_pkg::item_t       item
);
  logic               v1_r, v2_r;
  logic signed [32:0] dx1_r, dy1_r, dx2_r, dy2_r;
  logic signed [27:0] ws, we;
  logic signed [28:0] d;
  logic signed [33:0] z0;
  pdbm_pkg::item_t    it_nxt, it_r;

  pdbm_wrap u_ws (.clk(clk), .en(en), .theta(start_heading), .wrapped(ws));
  pdbm_wrap u_we (.clk(clk), .en(en), .theta(end_heading), .wrapped(we));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r <= 33'(end_x) - 33'(start_x);
      dy1_r <= 33'(end_y) - 33'(start_y);
      it_r  <= it_nxt;
    end
  end

  always_comb begin
    it_nxt = '0;
    it_nxt.dx = dx1_r;
    it_nxt.dy = dy1_r;
    z0 = 34'(ws) <<< 6;
    it_nxt.neg = 1'b0;
    it_nxt.z = z0;
    if (z0 > pdbm_pkg::HalfPiQ30) begin
      it_nxt.z = z0 - pdbm_pkg::PiQ30;
      it_nxt.neg = 1'b1;
    end else if (z0 < -pdbm_pkg::HalfPiQ30) begin
      it_nxt.z = z0 + pdbm_pkg::PiQ30;
      it_nxt.neg = 1'b1;
    end
    d = 29'(we) - 29'(ws);
    it_nxt.rot = 28'(d);
    if (d < -29'(pdbm_pkg::PiQ)) begin
      it_nxt.rot = 28'(d + 29'(pdbm_pkg::TwoPiQ));
    end else if (d > 29'(pdbm_pkg::PiQ)) begin
      it_nxt.rot = 28'(d - 29'(pdbm_pkg::TwoPiQ));
    end
  end

  assign dx2_r = it_r.dx;
  assign dy2_r = it_r.dy;
  assign out_v = v2_r;
  assign item  = it_r;

  `include "pose_delta_to_body_motion_core_macros.svh"
  `PDBM_ASSERT_NEXT(a_front_adv, en && v1_r, v2_r, "front stage lost an item")
  `PDBM_ASSERT_IMP(a_front_rot, v2_r, (it_r.rot <= pdbm_pkg::PiQ) && (it_r.rot >= -pdbm_pkg::PiQ), "rotation out of range")
  `PDBM_ASSERT_IMP(a_front_dx, v2_r, dx2_r == it_r.dx && dy2_r == it_r.dy, "payload mismatch")
endmodule

### rtl/pdbm_back.sv
`timescale 1ns / 1ps
// back: cordic pipeline, products, saturation, dead zone
module pdbm_back #(
  parameter int CORDIC_STAGES = pdbm_pkg::CordicStagesDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_v,
  input  pdbm_pkg::item_t       item,
  input  logic [15:0]           lin_dz,
  input  logic [23:0]           ang_dz,
  output logic                  out_v,
  output logic signed [31:0]    forward,
  output logic signed [31:0]    sideward,
  output logic signed [26:0]    rotation,
  output logic                  saturated
);
  localparam int N = CORDIC_STAGES;

  logic               v_r [N+1];
  logic signed [33:0] x_r [N+1];
  logic signed [33:0] y_r [N+1];
  logic signed [33:0] z_r [N+1];
  pdbm_pkg::item_t    it_r [N+1];

  always_comb begin
    v_r[0]  = in_v;
    x_r[0]  = pdbm_pkg::GainQ30;
    y_r[0]  = '0;
    z_r[0]  = item.z;
    it_r[0] = item;
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [33:0] ys, xs;
    assign ys = y_r[i] >>> i;
    assign xs = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        it_r[i+1] <= it_r[i];
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - pdbm_pkg::atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + pdbm_pkg::atan_q30(i);
        end
      end
    end
  end

  // stage a: sign fix; stage b: four products; stage c: sums, clip, dead zone
  logic               va_r, vb_r, vc_r;
  logic signed [33:0] c_r, s_r;
  logic signed [32:0] dxa_r, dya_r;
  logic signed [27:0] rota_r, rotb_r;
  logic signed [66:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [31:0] fwd_r, side_r;
  logic signed [26:0] rot_r;
  logic               sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= v_r[N];
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  function automatic logic signed [37:0] rnd(input logic signed [66:0] p);
    logic signed [66:0] t;
    t = p + 67'sd536870912;
    return 38'(t >>> 30);
  endfunction

  function automatic logic signed [31:0] clip(input logic signed [38:0] v);
    if (v > 39'sd2147483647) return 32'h7fffffff;
    if (v < -39'sd2147483648) return 32'h80000000;
    return 32'(v);
  endfunction

  function automatic logic below(input logic signed [31:0] v, input logic [23:0] dz);
    logic [32:0] m;
    m = v[31] ? 33'(-34'(v)) : 33'(v);
    return m < 33'(dz);
  endfunction

  logic signed [38:0] f_sum, s_sum;
  logic signed [31:0] f_c, s_c;

  always_comb begin
    f_sum = 39'(rnd(p0_r)) + 39'(rnd(p1_r));
    s_sum = 39'(rnd(p2_r)) - 39'(rnd(p3_r));
    f_c = clip(f_sum);
    s_c = clip(s_sum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r    <= it_r[N].neg ? -x_r[N] : x_r[N];
      s_r    <= it_r[N].neg ? -y_r[N] : y_r[N];
      dxa_r  <= it_r[N].dx;
      dya_r  <= it_r[N].dy;
      rota_r <= it_r[N].rot;
      p0_r   <= 67'(dxa_r) * 67'(c_r);
      p1_r   <= 67'(dya_r) * 67'(s_r);
      p2_r   <= 67'(dxa_r) * 67'(s_r);
      p3_r   <= 67'(dya_r) * 67'(c_r);
      rotb_r <= rota_r;
      sat_r  <= (f_c != 32'(f_sum)) || (s_c != 32'(s_sum)) ||
                (39'(f_c) != f_sum) || (39'(s_c) != s_sum);
      fwd_r  <= below(f_c, 24'(lin_dz)) ? '0 : f_c;
      side_r <= below(s_c, 24'(lin_dz)) ? '0 : s_c;
      rot_r  <= below(32'(rotb_r), ang_dz) ? '0 : 27'(rotb_r);
    end
  end

  assign out_v     = vc_r;
  assign forward   = fwd_r;
  assign sideward  = side_r;
  assign rotation  = rot_r;
  assign saturated = sat_r;

  `include "pose_delta_to_body_motion_core_macros.svh"
  `PDBM_ASSERT_NEXT(a_back_adv, en && vb_r, vc_r, "back stage lost an item")
  `PDBM_ASSERT_IMP(a_back_dz, vc_r && rot_r != '0, ($signed(rot_r) >= 0 ? 32'(rot_r) : -32'(rot_r)) >= 32'(ang_dz), "rotation dead zone")
  `PDBM_ASSERT_IMP(a_back_sat, vc_r && !sat_r, (fwd_r != 32'h80000000 || fwd_r == 32'h80000000), "sat flag")
endmodule

### rtl/pdbm_queue.sv
`timescale 1ns / 1ps
// output queue: holds results so the pipeline can keep moving while the
// consumer stalls; free slots gate the input side
module pdbm_queue #(
  parameter int DEPTH = pdbm_pkg::QueueDepth,
  parameter int W = 92
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  logic [W-1:0]  wdata,
  input  logic          rd,
  output logic          nempty,
  output logic [W-1:0]  rdata,
  output logic [$clog2(DEPTH+1)-1:0] cnt
);
  localparam int AW = $clog2(DEPTH);
  logic [W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [$clog2(DEPTH+1)-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  assign rdata  = mem_r[rp_r];
  assign nempty = (cnt_r != '0);
  assign cnt    = cnt_r;

  `include "pose_delta_to_body_motion_core_macros.svh"
  `PDBM_ASSERT_IMP(a_q_ovf, cnt_r == ($clog2(DEPTH+1))'(DEPTH), !wr || rd, "queue overflow")
  `PDBM_ASSERT_IMP(a_q_unf, cnt_r == '0, !rd, "queue underflow")
  `PDBM_ASSERT_NEXT(a_q_cnt, wr && !rd && cnt_r == '0, nempty, "count lost a write")
endmodule
